/* hdl/bta_pkg.sv */
// Package: widths, codes and shared types of the bakery ticket lock arbiter.
`timescale 1ns / 1ps

package bta_pkg;

	localparam int MAX_THREADS = 16;
	localparam int TICKET_BITS = 16;

	localparam int REQ_W     = 2;
	localparam int TID_W     = 4;
	localparam int ACT_W     = 5;
	localparam int OUT_TKT_W = 16;
	localparam int ST_W      = 2;

	localparam int IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CNT_W = $clog2(MAX_THREADS + 1);
	localparam int ID_W0 = (CNT_W > TID_W) ? CNT_W : TID_W;
	localparam int ID_W  = (ID_W0 > ACT_W) ? ID_W0 : ACT_W;

	localparam logic [TICKET_BITS-1:0] TICKET_MAX   = {TICKET_BITS{1'b1}};
	localparam logic [ACT_W-1:0]       ACTIVE_RESET = ACT_W'(16);

	typedef enum logic [REQ_W-1:0] {
		REQ_LOCK   = 2'd0,
		REQ_UNLOCK = 2'd1,
		REQ_POLL   = 2'd2
	} req_code_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_SAT   = 2'd1,
		ST_RANGE = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	// running result handed along the chain of cells
	typedef struct packed {
		logic [TICKET_BITS-1:0] max_tkt;
		logic                   nz_other;
		logic                   blk_sat;
		logic                   blk_poll;
	} acc_t;

	// controls seen by every cell
	typedef struct packed {
		logic                   shift;
		logic [ID_W-1:0]        me;
		logic [TICKET_BITS-1:0] mine;
		logic [ID_W-1:0]        n_use;
		logic                   wr_en;
		logic [TICKET_BITS-1:0] wr_data;
	} bcast_t;

endpackage

/* hdl/bta_if.sv */
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps

interface bta_req_if import bta_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [TID_W-1:0] thread_id;

	modport source (output valid, req_type, thread_id, input ready);
	modport sink   (input valid, req_type, thread_id, output ready);
endinterface

interface bta_rsp_if import bta_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OUT_TKT_W-1:0] ticket;
	logic                 granted;
	logic [ST_W-1:0]      status;

	modport source (output valid, ticket, granted, status, input ready);
	modport sink   (input valid, ticket, granted, status, output ready);
endinterface

/* hdl/bta_cell.sv */
// Cell: one thread's ticket and one step of the maximum and priority scan.
`timescale 1ns / 1ps

module bta_cell import bta_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ID_W-1:0]        idx,
	input  bcast_t                 bc,
	input  acc_t                   acc_in,
	output acc_t                   acc_out,
	output logic [TICKET_BITS-1:0] tkt
);

	logic [TICKET_BITS-1:0] tkt_q;
	acc_t                   acc_q;
	acc_t                   acc_nxt;
	logic                   counts;

	always_comb begin
		counts  = (idx < bc.n_use) && (idx != bc.me) && (tkt_q != '0);
		acc_nxt = acc_in;
		if ((idx < bc.n_use) && (tkt_q > acc_in.max_tkt)) begin
			acc_nxt.max_tkt = tkt_q;
		end
		if (counts) begin
			acc_nxt.nz_other = 1'b1;
			if ((tkt_q != TICKET_MAX) || (idx < bc.me)) begin
				acc_nxt.blk_sat = 1'b1;
			end
			if ((tkt_q < bc.mine) || ((tkt_q == bc.mine) && (idx < bc.me))) begin
				acc_nxt.blk_poll = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tkt_q <= '0;
			acc_q <= '0;
		end else begin
			if (bc.wr_en && (bc.me == idx)) begin
				tkt_q <= bc.wr_data;
			end
			if (bc.shift) begin
				acc_q <= acc_nxt;
			end
		end
	end

	assign acc_out = acc_q;
	assign tkt     = tkt_q;

endmodule

/* hdl/bakery_ticket_lock_arbiter.sv */
// Top level: bakery ticket lock arbiter with a scan chain of per-thread cells.
`timescale 1ns / 1ps
//
//  channel  dir  payload                           handshake
//  req      in   req_type[1:0], thread_id[3:0]     valid/ready
//  rsp      out  ticket[15:0], granted, status     valid/ready
//  cfg      in   cfg_wdata[4:0] (active_threads)   cfg_we
//
//  Lock and poll requests are accepted, pass through each cell of the scan chain
//  and then finish. Unlock and out-of-range requests skip the scan and finish.
//  One request is in flight at a time; a finished response waits in the output
//  register while the next request is accepted. Reset clears all tickets and sets
//  active_threads to 16. A stalled response holds the finish step until taken.

module bakery_ticket_lock_arbiter import bta_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ACT_W-1:0] cfg_wdata,
	bta_req_if.sink          req,
	bta_rsp_if.source        rsp
);

	state_t                 state_q;
	state_t                 state_nxt;
	logic [ACT_W-1:0]       active_q;
	logic [IDX_W-1:0]       cnt_q;
	logic [ID_W-1:0]        me_q;
	logic [REQ_W-1:0]       req_q;
	logic [TICKET_BITS-1:0] mine_q;
	logic                   range_q;

	logic                   rsp_valid_q;
	logic [OUT_TKT_W-1:0]   rsp_ticket_q;
	logic                   rsp_granted_q;
	logic [ST_W-1:0]        rsp_status_q;

	logic [ID_W-1:0]        n_use;
	logic [ID_W-1:0]        id_ext;
	logic [TICKET_BITS-1:0] mine_sel;
	logic                   accept;
	logic                   fin_fire;
	logic                   scan_en;
	logic                   skip_scan;

	logic [TICKET_BITS-1:0] new_tkt;
	logic                   sat;
	logic [OUT_TKT_W-1:0]   res_ticket;
	logic                   res_granted;
	logic [ST_W-1:0]        res_status;
	logic                   wr_en;
	logic [TICKET_BITS-1:0] wr_data;

	bcast_t                 bc;
	acc_t                   acc_chain [MAX_THREADS+1];
	logic [TICKET_BITS-1:0] tkts      [MAX_THREADS];

	assign n_use  = (ID_W'(active_q) > ID_W'(MAX_THREADS)) ? ID_W'(MAX_THREADS)
	                                                       : ID_W'(active_q);
	assign id_ext = ID_W'(req.thread_id);
	assign accept = req.valid && req.ready;
	assign skip_scan = (id_ext >= n_use) || (req.req_type == REQ_UNLOCK);

	always_comb begin
		mine_sel = '0;
		for (int k = 0; k < MAX_THREADS; k++) begin
			if (ID_W'(k) == id_ext) begin
				mine_sel = tkts[k];
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = skip_scan ? S_FIN : S_SCAN;
				end
			end
			S_SCAN: begin
				if (cnt_q == IDX_W'(MAX_THREADS - 1)) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_fire) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		scan_en   = 1'b0;
		fin_fire  = 1'b0;
		case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_SCAN: scan_en   = 1'b1;
			S_FIN:  fin_fire  = !rsp_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_comb begin
		sat         = (acc_chain[MAX_THREADS].max_tkt == TICKET_MAX);
		new_tkt     = sat ? TICKET_MAX : acc_chain[MAX_THREADS].max_tkt + 1'b1;
		res_ticket  = '0;
		res_granted = 1'b0;
		res_status  = ST_OK;
		wr_en       = 1'b0;
		wr_data     = '0;
		if (range_q) begin
			res_status = ST_RANGE;
		end else begin
			case (req_q)
				REQ_LOCK: begin
					res_ticket  = OUT_TKT_W'(new_tkt);
					res_granted = sat ? !acc_chain[MAX_THREADS].blk_sat
					                  : !acc_chain[MAX_THREADS].nz_other;
					res_status  = sat ? ST_SAT : ST_OK;
					wr_en       = fin_fire;
					wr_data     = new_tkt;
				end
				REQ_UNLOCK: begin
					wr_en = fin_fire;
				end
				default: begin
					res_ticket  = OUT_TKT_W'(mine_q);
					res_granted = (mine_q != '0) && !acc_chain[MAX_THREADS].blk_poll;
				end
			endcase
		end
	end

	assign bc.shift   = scan_en;
	assign bc.me      = me_q;
	assign bc.mine    = mine_q;
	assign bc.n_use   = n_use;
	assign bc.wr_en   = wr_en;
	assign bc.wr_data = wr_data;

	assign acc_chain[0] = '0;

	for (genvar k = 0; k < MAX_THREADS; k++) begin : g_cell
		bta_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (ID_W'(k)),
			.bc      (bc),
			.acc_in  (acc_chain[k]),
			.acc_out (acc_chain[k+1]),
			.tkt     (tkts[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= ACTIVE_RESET;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (scan_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			me_q    <= id_ext;
			req_q   <= req.req_type;
			mine_q  <= mine_sel;
			range_q <= id_ext >= n_use;
		end
		if (fin_fire) begin
			rsp_ticket_q  <= res_ticket;
			rsp_granted_q <= res_granted;
			rsp_status_q  <= res_status;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.ticket  = rsp_ticket_q;
	assign rsp.granted = rsp_granted_q;
	assign rsp.status  = rsp_status_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while a request is in flight");

	a_range_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_RANGE)) |-> ((rsp.ticket == '0) && !rsp.granted))
		else $error("out-of-range response carries a ticket or grant");

	a_grant_needs_ticket: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.granted) |-> (rsp.ticket != '0))
		else $error("grant without a ticket");

	a_sat_ticket: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_SAT)) |-> (rsp.ticket == OUT_TKT_W'(TICKET_MAX)))
		else $error("saturated response without maximum ticket");

endmodule

/* test/bakery_ticket_lock_arbiter_tb.sv */
// Testbench: self-checking regression of the bakery ticket lock arbiter with its own ticket model.
`timescale 1ns / 1ps

module bakery_ticket_lock_arbiter_tb;
	import bta_pkg::*;

	localparam int                CLK_PERIOD = 8;
	localparam int                STALL_LIMIT = 1000;
	localparam logic [REQ_W-1:0]  REQ_SPARE = 2'd3;

	typedef struct packed {
		logic [OUT_TKT_W-1:0] ticket;
		logic                 granted;
		status_code_t         status;
	} resp_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [ACT_W-1:0] cfg_wdata;

	bta_req_if req_if();
	bta_rsp_if rsp_if();

	bakery_ticket_lock_arbiter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	// ticket model state
	logic [TICKET_BITS-1:0] ticket_book [MAX_THREADS];
	logic [ACT_W-1:0]       thread_cnt;
	resp_t                  pending_resp_q [$];

	int  err_cnt;
	int  req_cnt;
	int  resp_cnt;
	int  sat_cnt;
	int  range_cnt;
	int  grant_cnt;
	int  burst_left;
	bit  steady;
	int  quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int threads_live();
		return (thread_cnt > MAX_THREADS) ? MAX_THREADS : int'(thread_cnt);
	endfunction

	function automatic logic holds_turn(int me, int n);
		logic [TICKET_BITS-1:0] mine;
		mine = ticket_book[me];
		if (mine == '0)
			return 1'b0;
		for (int k = 0; k < n; k++) begin
			if (k == me || ticket_book[k] == '0)
				continue;
			if (ticket_book[k] < mine || (ticket_book[k] == mine && k < me))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic resp_t serve_request(logic [REQ_W-1:0] rt, logic [TID_W-1:0] tid);
		int                     n;
		logic [TICKET_BITS-1:0] top;
		resp_t                  r;
		n = threads_live();
		r.ticket = '0;
		r.granted = 1'b0;
		r.status = ST_OK;
		if (int'(tid) >= n) begin
			r.status = ST_RANGE;
			return r;
		end
		case (rt)
			REQ_LOCK: begin
				top = '0;
				for (int k = 0; k < n; k++)
					if (ticket_book[k] > top)
						top = ticket_book[k];
				if (top == TICKET_MAX) begin
					ticket_book[tid] = TICKET_MAX;
					r.status = ST_SAT;
				end else begin
					ticket_book[tid] = top + 1'b1;
				end
				r.ticket = OUT_TKT_W'(ticket_book[tid]);
				r.granted = holds_turn(int'(tid), n);
			end
			REQ_UNLOCK: begin
				ticket_book[tid] = '0;
			end
			default: begin
				r.ticket = OUT_TKT_W'(ticket_book[tid]);
				r.granted = holds_turn(int'(tid), n);
			end
		endcase
		return r;
	endfunction

	task automatic send_req(input logic [REQ_W-1:0] rt, input logic [TID_W-1:0] tid);
		resp_t r;
		req_if.valid <= 1'b1;
		req_if.req_type <= rt;
		req_if.thread_id <= tid;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		r = serve_request(rt, tid);
		pending_resp_q.push_back(r);
		req_cnt++;
		if (r.status == ST_SAT)
			sat_cnt++;
		if (r.status == ST_RANGE)
			range_cnt++;
		if (r.granted)
			grant_cnt++;
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(0, 7) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12))
				@(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) :
				$urandom_range(0, 12);
		end
	endtask

	// drop valid and hold until every expected response is back
	task automatic wait_drain();
		req_if.valid <= 1'b0;
		while (pending_resp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_threads(input logic [ACT_W-1:0] v);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		thread_cnt = v;
	endtask

	// receiver: ready pattern follows a randomly reselected mode
	initial begin
		int rx_cnt;
		int rx_mode;
		rx_cnt = 0;
		rx_mode = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cnt++;
			if (rx_cnt % 256 == 0)
				rx_mode = $urandom_range(0, 3);
			if (steady || rx_mode == 0)
				rsp_if.ready <= 1'b1;
			else if (rx_mode == 1)
				rsp_if.ready <= ($urandom_range(0, 3) != 0);
			else if (rx_mode == 2)
				rsp_if.ready <= ((rx_cnt % 37) >= 15);
			else
				rsp_if.ready <= ($urandom_range(0, 1) == 1);
		end
	end

	always @(posedge clk) begin : resp_check
		resp_t want;
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_resp_q.size() == 0) begin
				$error("unexpected response: ticket %0d granted %0d status %0d",
					rsp_if.ticket, rsp_if.granted, rsp_if.status);
				err_cnt++;
			end else begin
				want = pending_resp_q.pop_front();
				resp_cnt++;
				if (rsp_if.ticket !== want.ticket) begin
					$error("ticket: expected %0d, got %0d", want.ticket, rsp_if.ticket);
					err_cnt++;
				end
				if (rsp_if.granted !== want.granted) begin
					$error("granted: expected %0d, got %0d", want.granted, rsp_if.granted);
					err_cnt++;
				end
				if (rsp_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_if.status);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
				(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic test_after_reset();
		send_req(REQ_POLL, 4'd0);
		send_req(REQ_POLL, 4'd15);
		send_req(REQ_UNLOCK, 4'd9);
	endtask

	task automatic test_lock_order();
		set_threads(ACT_W'(16));
		send_req(REQ_LOCK, 4'd0);
		send_req(REQ_LOCK, 4'd15);
		send_req(REQ_POLL, 4'd15);
		send_req(REQ_POLL, 4'd0);
		send_req(REQ_LOCK, 4'd0);
		send_req(REQ_POLL, 4'd15);
		send_req(REQ_SPARE, 4'd15);
		send_req(REQ_SPARE, 4'd0);
		send_req(REQ_UNLOCK, 4'd15);
		send_req(REQ_POLL, 4'd0);
		send_req(REQ_UNLOCK, 4'd0);
		send_req(REQ_UNLOCK, 4'd7);
		send_req(REQ_POLL, 4'd7);
	endtask

	task automatic test_thread_range();
		set_threads(ACT_W'(1));
		send_req(REQ_LOCK, 4'd0);
		send_req(REQ_LOCK, 4'd1);
		send_req(REQ_POLL, 4'd15);
		set_threads(ACT_W'(0));
		send_req(REQ_LOCK, 4'd0);
		send_req(REQ_UNLOCK, 4'd0);
		send_req(REQ_POLL, 4'd0);
		set_threads(ACT_W'(31));
		send_req(REQ_LOCK, 4'd15);
		send_req(REQ_POLL, 4'd0);
		set_threads(ACT_W'(17));
		send_req(REQ_UNLOCK, 4'd15);
		send_req(REQ_UNLOCK, 4'd0);
	endtask

	task automatic test_inactive_keep();
		set_threads(ACT_W'(16));
		send_req(REQ_LOCK, 4'd10);
		send_req(REQ_LOCK, 4'd10);
		set_threads(ACT_W'(4));
		send_req(REQ_LOCK, 4'd0);
		send_req(REQ_POLL, 4'd10);
		set_threads(ACT_W'(16));
		send_req(REQ_POLL, 4'd10);
		send_req(REQ_POLL, 4'd0);
		send_req(REQ_UNLOCK, 4'd10);
		send_req(REQ_UNLOCK, 4'd0);
	endtask

	// climb thread 0 back to back with only one thread active, then mix in others
	task automatic test_ticket_climb();
		set_threads(ACT_W'(1));
		steady = 1'b1;
		repeat (40)
			send_req(REQ_LOCK, 4'd0);
		steady = 1'b0;
		set_threads(ACT_W'(16));
		send_req(REQ_LOCK, 4'd5);
		send_req(REQ_POLL, 4'd0);
		send_req(REQ_LOCK, 4'd0);
		send_req(REQ_UNLOCK, 4'd0);
		send_req(REQ_POLL, 4'd5);
		send_req(REQ_LOCK, 4'd3);
		send_req(REQ_POLL, 4'd5);
		for (int k = 0; k < MAX_THREADS; k++)
			send_req(REQ_UNLOCK, TID_W'(k));
	endtask

	task automatic test_random(input int total);
		int                 counts [9];
		int                 per_phase;
		int                 n;
		int                 pick;
		logic [REQ_W-1:0]   rt;
		logic [TID_W-1:0]   tid;
		counts = '{16, 5, 1, 16, 2, 31, 0, 12, 16};
		per_phase = total / 9;
		foreach (counts[p]) begin
			set_threads(ACT_W'(counts[p]));
			n = threads_live();
			for (int i = 0; i < ((n == 0) ? 20 : per_phase); i++) begin
				if (n > 0 && $urandom_range(0, 99) < 85)
					tid = TID_W'($urandom_range(0, n - 1));
				else
					tid = TID_W'($urandom_range(0, MAX_THREADS - 1));
				pick = $urandom_range(0, 99);
				if (pick < 30)
					rt = REQ_LOCK;
				else if (pick < 55)
					rt = REQ_UNLOCK;
				else if (pick < 95)
					rt = REQ_POLL;
				else
					rt = REQ_SPARE;
				send_req(rt, tid);
				if (i == per_phase / 2 || $urandom_range(0, 79) == 0)
					wait_drain();
			end
		end
	endtask

	initial begin
		err_cnt = 0;
		req_cnt = 0;
		resp_cnt = 0;
		sat_cnt = 0;
		range_cnt = 0;
		grant_cnt = 0;
		quiet_cycles = 0;
		steady = 1'b0;
		burst_left = 0;
		thread_cnt = ACTIVE_RESET;
		foreach (ticket_book[k])
			ticket_book[k] = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_POLL;
		req_if.thread_id <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_lock_order();
		test_thread_range();
		test_inactive_keep();
		test_ticket_climb();
		test_random(850);

		wait_drain();
		repeat (40) @(posedge clk);
		while (pending_resp_q.size() != 0) begin
			$error("response never arrived: ticket %0d", pending_resp_q[0].ticket);
			void'(pending_resp_q.pop_front());
			err_cnt++;
		end
		$display("%0d requests sent, %0d responses checked over thread counts 0 to 31",
			req_cnt, resp_cnt);
		$display("%0d granted, %0d saturated tickets, %0d out-of-range threads",
			grant_cnt, sat_cnt, range_cnt);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
